// ===== rtl/ddc_pkg.sv =====
// ddc_pkg: shared types, codes, constants and rounding helpers of the down-converter
// used by digital_down_converter; depends on nothing else
package ddc_pkg;

	// default sizes
	localparam int MAX_TAPS_DEF  = 64;
	localparam int ACC_FRAC_DEF  = 24;

	// field widths
	localparam int SMP_W  = 16;
	localparam int PH_W   = 18;
	localparam int COEF_W = 18;
	localparam int OUT_W  = 24;
	localparam int PROD_W = 36;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int TAP_W  = 6;
	localparam int CIDX_W = 6;

	// request opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM    = 2'd3;

	// reset values
	localparam logic [TAP_W-1:0]      TAP_COUNT_RST = 6'd63;
	localparam logic signed [PH_W-1:0] PH_ONE       = 18'sd65536;
	localparam logic signed [PH_W-1:0] PH_ZERO      = 18'sd0;

	// accumulator operations of the shared complex mac
	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_LOAD  = 2'd1;
	localparam logic [1:0] ACC_ADD   = 2'd2;
	localparam logic [1:0] ACC_CROSS = 2'd3;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [PH_W-1:0]  a0;
		logic signed [PH_W-1:0]  b0;
		logic signed [PH_W-1:0]  a1;
		logic signed [PH_W-1:0]  b1;
	} mac_req_t;

	typedef struct packed {
		logic                     clip;
		logic signed [OUT_W-1:0]  val;
	} fir_out_t;

	// round half up by 16 bits, saturate to 18 bits
	function automatic logic signed [PH_W-1:0] rnd_sat18(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = (v + 64'sd32768) >>> 16;
		if (t > 64'sd131071)
			return 18'sd131071;
		if (t < -64'sd131072)
			return -18'sd131072;
		return t[PH_W-1:0];
	endfunction

	// round half up by 17 bits, saturate to 24 bits and flag it
	function automatic fir_out_t fir_round(input logic signed [63:0] v);
		logic signed [63:0] t;
		fir_out_t r;
		t = (v + 64'sd65536) >>> 17;
		r.clip = 1'b1;
		if (t > 64'sd8388607)
			r.val = 24'sd8388607;
		else if (t < -64'sd8388608)
			r.val = -24'sd8388608;
		else begin
			r.val  = t[OUT_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/digital_down_converter.sv =====
// digital_down_converter: i/q mixer, fractional decimator and band-pass fir
// built around one shared complex multiply-accumulate; uses ddc_pkg
//
// A coefficient request (op 1) is written as it is taken and never stalls the input. A
// sample request runs on the single complex multiply-accumulate: the phasor update
// (ROT_A, ROT_B), the mix (MIX_A, MIX_B) and, when it emits, one tap per cycle through
// the delay and coefficient memories for the n taps in use (tap_count with bit 0 set,
// capped at MAX_TAPS), then pipeline drain and a wait until the output register is free.
// in_stall is high for the whole of that time. A finished result sits in the output
// register while the next request is already being worked on. Delay-line entries read
// as zero until first written after reset; coefficients must be written before use.
module digital_down_converter #(
	parameter int MAX_TAPS      = ddc_pkg::MAX_TAPS_DEF,
	parameter int ACC_FRAC_BITS = ddc_pkg::ACC_FRAC_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ddc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ddc_pkg::CFG_DATA_W-1:0]        cfg_data,
	// requests
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic signed [ddc_pkg::SMP_W-1:0]      sample_re,
	input  logic signed [ddc_pkg::SMP_W-1:0]      sample_im,
	input  logic [ddc_pkg::CIDX_W-1:0]            coef_index,
	input  logic signed [ddc_pkg::COEF_W-1:0]     coef_value,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ddc_pkg::OUT_W-1:0]      out_re,
	output logic signed [ddc_pkg::OUT_W-1:0]      out_im,
	output logic                                  clipped
);

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int NW0   = $clog2(MAX_TAPS + 1);
	localparam int N_W   = (NW0 > ddc_pkg::TAP_W) ? NW0 : ddc_pkg::TAP_W;
	localparam int ACC_W = ddc_pkg::PROD_W + AW + 1;
	localparam int DA_W  = ACC_FRAC_BITS + 2;
	localparam int RR_W  = (ACC_FRAC_BITS + 1 > ddc_pkg::CFG_DATA_W) ?
		ACC_FRAC_BITS + 1 : ddc_pkg::CFG_DATA_W;
	localparam int DLY_W = 2 * ddc_pkg::PH_W;
	localparam int PW    = ddc_pkg::PH_W;

	localparam logic [RR_W-1:0]        RATIO_ONE = RR_W'(1) << ACC_FRAC_BITS;
	localparam logic signed [DA_W-1:0] DEC_ONE   = DA_W'(1) << ACC_FRAC_BITS;
	localparam logic [N_W-1:0]         TAPS_MAX  = N_W'(MAX_TAPS);
	localparam logic [AW-1:0]          ADDR_LAST = AW'(MAX_TAPS - 1);
	localparam logic signed [PW-1:0]   PH_ZERO_L = ddc_pkg::PH_ZERO;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ROT_A = 4'd1;
	localparam logic [3:0] ST_ROT_B = 4'd2;
	localparam logic [3:0] ST_ROT_W = 4'd3;
	localparam logic [3:0] ST_MIX_A = 4'd4;
	localparam logic [3:0] ST_MIX_B = 4'd5;
	localparam logic [3:0] ST_MIX_W = 4'd6;
	localparam logic [3:0] ST_FIR   = 4'd7;
	localparam logic [3:0] ST_FIR_W = 4'd8;

	// configuration registers
	logic [ddc_pkg::TAP_W-1:0] tap_count_q;
	logic [RR_W-1:0]           rate_ratio_q;
	logic signed [PW-1:0]      step_re_q;
	logic signed [PW-1:0]      step_im_q;

	// sequencer and state
	logic [3:0]                state_q;
	logic signed [PW-1:0]      rotor_re_q;
	logic signed [PW-1:0]      rotor_im_q;
	logic signed [DA_W-1:0]    decim_q;
	logic [AW-1:0]             head_q;
	logic [AW-1:0]             pos_q;
	logic [N_W-1:0]            k_q;
	logic signed [ddc_pkg::SMP_W-1:0] smp_re_q;
	logic signed [ddc_pkg::SMP_W-1:0] smp_im_q;

	// memories
	logic [DLY_W-1:0]               dly_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]            dly_vld_q;
	logic signed [ddc_pkg::COEF_W-1:0] coef_mem [MAX_TAPS];

	// fir read stage
	logic                           rd_vld_s1;
	logic                           rd_first_s1;
	logic [DLY_W-1:0]               dly_rd_s1;
	logic                           dly_ok_s1;
	logic signed [ddc_pkg::COEF_W-1:0] coef_rd_s1;

	// mac stages
	ddc_pkg::mac_req_t              mreq;
	logic signed [ddc_pkg::PROD_W-1:0] mul0;
	logic signed [ddc_pkg::PROD_W-1:0] mul1;
	logic [1:0]                     op_s2;
	logic signed [ddc_pkg::PROD_W-1:0] p0_s2;
	logic signed [ddc_pkg::PROD_W-1:0] p1_s2;
	logic signed [ACC_W-1:0]        acc0_q;
	logic signed [ACC_W-1:0]        acc1_q;

	// outputs
	logic                           out_valid_q;
	logic signed [ddc_pkg::OUT_W-1:0] out_re_q;
	logic signed [ddc_pkg::OUT_W-1:0] out_im_q;
	logic                           clipped_q;

	// helpers
	logic                           in_take;
	logic                           coef_we;
	logic [N_W-1:0]                 cidx_ext;
	logic [ddc_pkg::TAP_W-1:0]      tap_odd;
	logic [N_W-1:0]                 n_taps;
	logic                           pipe_empty;
	logic                           out_free;
	logic                           out_load;
	logic [RR_W-1:0]                ratio_lim;
	logic signed [DA_W-1:0]         decim_sum;
	logic                           emit;
	logic signed [PW-1:0]           acc0_r18;
	logic signed [PW-1:0]           acc1_r18;
	ddc_pkg::fir_out_t              fir_re;
	ddc_pkg::fir_out_t              fir_im;
	logic [AW-1:0]                  head_nxt;
	logic [AW-1:0]                  pos_nxt;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cidx_ext  = N_W'(coef_index);
	assign coef_we   = in_take && (op == ddc_pkg::OP_COEF) && (cidx_ext < TAPS_MAX);

	assign tap_odd = {tap_count_q[ddc_pkg::TAP_W-1:1], 1'b1};
	assign n_taps  = (N_W'(tap_odd) > TAPS_MAX) ? TAPS_MAX : N_W'(tap_odd);

	assign pipe_empty = (op_s2 == ddc_pkg::ACC_NONE) && !rd_vld_s1;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (state_q == ST_FIR_W) && pipe_empty && out_free;

	assign ratio_lim = (rate_ratio_q > RATIO_ONE) ? RATIO_ONE : rate_ratio_q;
	assign decim_sum = decim_q + $signed({1'b0, ratio_lim[DA_W-2:0]});
	assign emit      = !decim_sum[DA_W-1] && (decim_sum != '0);

	assign acc0_r18 = ddc_pkg::rnd_sat18(64'(acc0_q));
	assign acc1_r18 = ddc_pkg::rnd_sat18(64'(acc1_q));
	assign fir_re   = ddc_pkg::fir_round(64'(acc0_q));
	assign fir_im   = ddc_pkg::fir_round(64'(acc1_q));

	assign head_nxt = (head_q == ADDR_LAST) ? '0 : head_q + AW'(1);
	assign pos_nxt  = (pos_q == '0) ? ADDR_LAST : pos_q - AW'(1);

	// operand selection for the shared complex mac
	always_comb begin
		mreq    = '0;
		mreq.op = ddc_pkg::ACC_NONE;
		if (rd_vld_s1) begin
			mreq.op = rd_first_s1 ? ddc_pkg::ACC_LOAD : ddc_pkg::ACC_ADD;
			mreq.a0 = dly_ok_s1 ? $signed(dly_rd_s1[DLY_W-1:PW]) : PH_ZERO_L;
			mreq.a1 = dly_ok_s1 ? $signed(dly_rd_s1[PW-1:0]) : PH_ZERO_L;
			mreq.b0 = coef_rd_s1;
			mreq.b1 = coef_rd_s1;
		end else begin
			unique case (state_q)
				ST_ROT_A: begin
					mreq.op = ddc_pkg::ACC_LOAD;
					mreq.a0 = rotor_re_q;
					mreq.a1 = rotor_re_q;
					mreq.b0 = step_re_q;
					mreq.b1 = step_im_q;
				end
				ST_ROT_B: begin
					mreq.op = ddc_pkg::ACC_CROSS;
					mreq.a0 = rotor_im_q;
					mreq.a1 = rotor_im_q;
					mreq.b0 = step_im_q;
					mreq.b1 = step_re_q;
				end
				ST_MIX_A: begin
					mreq.op = ddc_pkg::ACC_LOAD;
					mreq.a0 = PW'(smp_re_q);
					mreq.a1 = PW'(smp_re_q);
					mreq.b0 = rotor_re_q;
					mreq.b1 = rotor_im_q;
				end
				ST_MIX_B: begin
					mreq.op = ddc_pkg::ACC_CROSS;
					mreq.a0 = PW'(smp_im_q);
					mreq.a1 = PW'(smp_im_q);
					mreq.b0 = rotor_im_q;
					mreq.b1 = rotor_re_q;
				end
				default: begin
					mreq.op = ddc_pkg::ACC_NONE;
				end
			endcase
		end
	end

	assign mul0 = mreq.a0 * mreq.b0;
	assign mul1 = mreq.a1 * mreq.b1;

	// product registers, then the accumulators
	always_ff @(posedge clk) begin
		p0_s2 <= mul0;
		p1_s2 <= mul1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= ddc_pkg::ACC_NONE;
		end else begin
			op_s2 <= mreq.op;
		end
	end

	always_ff @(posedge clk) begin
		case (op_s2)
			ddc_pkg::ACC_LOAD: begin
				acc0_q <= ACC_W'(p0_s2);
				acc1_q <= ACC_W'(p1_s2);
			end
			ddc_pkg::ACC_ADD: begin
				acc0_q <= acc0_q + ACC_W'(p0_s2);
				acc1_q <= acc1_q + ACC_W'(p1_s2);
			end
			ddc_pkg::ACC_CROSS: begin
				acc0_q <= acc0_q - ACC_W'(p0_s2);
				acc1_q <= acc1_q + ACC_W'(p1_s2);
			end
			default: begin
				acc0_q <= acc0_q;
				acc1_q <= acc1_q;
			end
		endcase
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[cidx_ext[AW-1:0]] <= coef_value;
		if (state_q == ST_MIX_W && pipe_empty)
			dly_mem[head_q] <= {acc0_r18, acc1_r18};
		dly_rd_s1  <= dly_mem[pos_q];
		coef_rd_s1 <= coef_mem[k_q[AW-1:0]];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= ddc_pkg::TAP_COUNT_RST;
			rate_ratio_q <= RATIO_ONE;
			step_re_q    <= ddc_pkg::PH_ONE;
			step_im_q    <= ddc_pkg::PH_ZERO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ddc_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg_data[ddc_pkg::TAP_W-1:0];
				ddc_pkg::CFG_RATE_RATIO: rate_ratio_q <= RR_W'(cfg_data);
				ddc_pkg::CFG_STEP_RE:    step_re_q    <= $signed(cfg_data[PW-1:0]);
				ddc_pkg::CFG_STEP_IM:    step_im_q    <= $signed(cfg_data[PW-1:0]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			smp_re_q <= sample_re;
			smp_im_q <= sample_im;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rotor_re_q  <= ddc_pkg::PH_ZERO;
			rotor_im_q  <= ddc_pkg::PH_ONE;
			decim_q     <= -DEC_ONE;
			head_q      <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			dly_vld_q   <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			dly_ok_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1   <= (state_q == ST_FIR);
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && op == ddc_pkg::OP_SAMPLE)
						state_q <= ST_ROT_A;
				end
				ST_ROT_A: state_q <= ST_ROT_B;
				ST_ROT_B: state_q <= ST_ROT_W;
				ST_ROT_W: begin
					if (pipe_empty) begin
						rotor_re_q <= acc0_r18;
						rotor_im_q <= acc1_r18;
						state_q    <= ST_MIX_A;
					end
				end
				ST_MIX_A: state_q <= ST_MIX_B;
				ST_MIX_B: state_q <= ST_MIX_W;
				ST_MIX_W: begin
					if (pipe_empty) begin
						dly_vld_q[head_q] <= 1'b1;
						head_q <= head_nxt;
						pos_q  <= head_q;
						k_q    <= '0;
						if (emit) begin
							decim_q <= decim_sum - DEC_ONE;
							state_q <= ST_FIR;
						end else begin
							decim_q <= decim_sum;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIR: begin
					rd_first_s1 <= (k_q == '0);
					dly_ok_s1   <= dly_vld_q[pos_q];
					pos_q       <= pos_nxt;
					k_q         <= k_q + N_W'(1);
					if (k_q == n_taps - N_W'(1))
						state_q <= ST_FIR_W;
				end
				ST_FIR_W: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_re_q  <= fir_re.val;
			out_im_q  <= fir_im.val;
			clipped_q <= fir_re.clip | fir_im.clip;
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign clipped   = clipped_q;

	// checks
	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		op_s2 != ddc_pkg::ACC_NONE |-> state_q != ST_IDLE)
		else $error("mac busy while sequencer idle");

	a_fir_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIR |-> k_q < n_taps)
		else $error("tap counter past tap count");

	a_rd_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_FIR || state_q == ST_FIR_W))
		else $error("tap read outside fir pass");

	a_decim_range: assert property (@(posedge clk) disable iff (!arst_n)
		(decim_q >= -DEC_ONE) && (decim_q[DA_W-1] || decim_q == '0))
		else $error("decimation accumulator out of range");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && op == ddc_pkg::OP_SAMPLE |=> state_q == ST_ROT_A)
		else $error("sample request did not start phasor update");

endmodule
